/* rtl/jws_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Jaro-Winkler similarity package
// Shared transaction types, command codes and register indexes.
// ----------------------------------------------------------------------------
package jws_pkg;

	// Command codes carried in the kind field.
	localparam logic [1:0] KIND_FIRST   = 2'd0;
	localparam logic [1:0] KIND_SECOND  = 2'd1;
	localparam logic [1:0] KIND_COMPUTE = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_BOOST_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_PREFIX_SCALE    = 2'd1;
	localparam logic [1:0] REG_PREFIX_LIMIT    = 2'd2;

	// Register reset values.
	localparam logic [16:0] BOOST_THRESHOLD_RST = 17'd45875;
	localparam logic [14:0] PREFIX_SCALE_RST    = 15'd6554;
	localparam logic [3:0]  PREFIX_LIMIT_RST    = 4'd4;

	// One in Q16.
	localparam logic [16:0] Q16_ONE = 17'd65536;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] char_value;
	} cmd_t;

	typedef struct packed {
		logic [16:0] similarity;
		logic [16:0] jaro_score;
		logic [6:0]  match_count;
		logic [6:0]  mismatch_pairs;
		logic [3:0]  prefix_length;
		logic        truncated;
	} result_t;

endpackage

`default_nettype wire

/* rtl/jaro_winkler_similarity_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Jaro-Winkler similarity engine
// Loads two words byte by byte and scores them with a sequenced datapath.
// ----------------------------------------------------------------------------
// A load transaction (kind 0 or 1) is taken without raising busy, so bytes
// can stream in every cycle. A compute transaction raises busy and runs a
// sequencer over one shared multiplier and the divider's subtractor: the
// match walk starts each row of the first word, skips taken slots, probes
// each free slot and closes a window with no match; the transposition pass
// steps through the matched positions of each word; then come five multiply
// steps, a setup step and a 17-step restoring divider, a threshold check,
// and, when the bonus applies, a walk over the prefix characters and three
// more steps, then an output step. The result appears on result with done
// high for a single cycle; the receiver cannot stall it, so it must be
// taken in that cycle.
module jaro_winkler_similarity_top
	import jws_pkg::*;
#(
	parameter int MAX_LEN = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  cmd_t        cmd,
	output logic        busy,
	output logic        done,
	output result_t     result,
	input  wire         cfg_wr_en,
	input  wire  [1:0]  cfg_addr,
	input  wire  [16:0] cfg_wdata
);

	localparam int LW  = $clog2(MAX_LEN + 1);
	localparam int AW  = $clog2(MAX_LEN);
	localparam int SW  = LW + 3;
	localparam int NW  = 3 * LW + 3;
	localparam int RW  = NW + 16;
	localparam int MXW = (2 * LW > 19) ? 2 * LW : 19;
	localparam int MYW = (LW + 1 > 17) ? LW + 1 : 17;
	localparam int PW  = MXW + MYW;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MROW, ST_MCOL, ST_MCMP, ST_TI, ST_TK, ST_TCMP,
		ST_MU1, ST_MU2, ST_MU3, ST_MU4, ST_MU5, ST_DINIT, ST_DIV,
		ST_BCHK, ST_PCHK, ST_PCMP, ST_BM1, ST_BM2, ST_SUM, ST_OUT
	} state_t;

	state_t state_q;

	// Word stores and their registered read ports.
	logic [7:0] w1_mem [MAX_LEN];
	logic [7:0] w2_mem [MAX_LEN];
	logic [7:0] rd1_q, rd2_q;

	logic [16:0] thr_q;
	logic [14:0] scale_q;
	logic [3:0]  plim_q;

	logic [LW-1:0] l1_q, l2_q, i_q, j_q, hi_q, m_q, c_q;
	logic [MAX_LEN-1:0] fm_q, sm_q;
	logic ovf_q;
	logic signed [SW-1:0] win_q;

	logic [2*LW-1:0] mm_q, l12_q;
	logic [NW-1:0]   pa_q, num_q, den_q;
	logic [RW-1:0]   rem_q, ds_q;
	logic [16:0]     quo_q, jaro_q;
	logic [4:0]      cnt_q;
	logic [3:0]      p_q;
	logic [18:0]     ps_q;
	logic [19:0]     bon_q;

	logic accept, load1, load2;
	assign accept = start && !busy;
	assign load1  = accept && (cmd.kind == KIND_FIRST) && (l1_q < LW'(MAX_LEN));
	assign load2  = accept && (cmd.kind == KIND_SECOND) && (l2_q < LW'(MAX_LEN));
	assign busy   = (state_q != ST_IDLE);

	// Word store writes and registered reads.
	always_ff @(posedge clk) begin
		if (load1) begin
			w1_mem[l1_q[AW-1:0]] <= cmd.char_value;
		end
		if (load2) begin
			w2_mem[l2_q[AW-1:0]] <= cmd.char_value;
		end
		rd1_q <= w1_mem[i_q[AW-1:0]];
		rd2_q <= w2_mem[j_q[AW-1:0]];
	end

	// Shared multiplier operand selection.
	logic [MXW-1:0] mul_x;
	logic [MYW-1:0] mul_y;
	logic [PW-1:0]  prod;
	always_comb begin
		mul_x = '0;
		mul_y = '0;
		case (state_q)
			ST_MU1: begin
				mul_x = MXW'(m_q);
				mul_y = MYW'(m_q);
			end
			ST_MU2: begin
				mul_x = MXW'(mm_q);
				mul_y = MYW'(l1_q) + MYW'(l2_q);
			end
			ST_MU3: begin
				mul_x = MXW'(l1_q);
				mul_y = MYW'(l2_q);
			end
			ST_MU4: begin
				mul_x = MXW'(l12_q);
				mul_y = (MYW'(m_q) << 1) - MYW'(c_q);
			end
			ST_MU5: begin
				mul_x = MXW'(l12_q);
				mul_y = MYW'(m_q);
			end
			ST_BM1: begin
				mul_x = MXW'(p_q);
				mul_y = MYW'(scale_q);
			end
			ST_BM2: begin
				mul_x = MXW'(ps_q);
				mul_y = MYW'(Q16_ONE - jaro_q);
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end
	assign prod = PW'(mul_x) * PW'(mul_y);

	// Match window bounds for the current row of the first word.
	logic [LW-1:0] maxl;
	logic signed [SW-1:0] lo_s, hi_s;
	assign maxl = (l1_q > l2_q) ? l1_q : l2_q;
	assign lo_s = $signed(SW'(i_q)) - win_q;
	assign hi_s = $signed(SW'(i_q)) + win_q + SW'(1);

	// Divider trial subtraction and bonus sum.
	logic [RW:0]   trial;
	logic [20:0]   sum;
	assign trial = {1'b0, rem_q} - {1'b0, ds_q};
	assign sum   = 21'(jaro_q) + 21'(bon_q);

	logic [LW+3:0] i_ext, plim_ext;
	assign i_ext    = (LW+4)'(i_q);
	assign plim_ext = (LW+4)'(plim_q);

	// Sequencer, registers and result outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			thr_q   <= BOOST_THRESHOLD_RST;
			scale_q <= PREFIX_SCALE_RST;
			plim_q  <= PREFIX_LIMIT_RST;
			l1_q    <= '0;
			l2_q    <= '0;
			fm_q    <= '0;
			sm_q    <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			m_q     <= '0;
			c_q     <= '0;
			cnt_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_BOOST_THRESHOLD: thr_q   <= cfg_wdata;
					REG_PREFIX_SCALE:    scale_q <= cfg_wdata[14:0];
					REG_PREFIX_LIMIT:    plim_q  <= cfg_wdata[3:0];
					default:             ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (load1) begin
						l1_q <= l1_q + LW'(1);
					end else if (load2) begin
						l2_q <= l2_q + LW'(1);
					end else if (accept && (cmd.kind == KIND_FIRST ||
					                        cmd.kind == KIND_SECOND)) begin
						ovf_q <= 1'b1;
					end else if (accept && cmd.kind == KIND_COMPUTE) begin
						m_q   <= '0;
						c_q   <= '0;
						i_q   <= '0;
						j_q   <= '0;
						win_q <= $signed(SW'(maxl >> 1)) - SW'(1);
						if (l1_q == '0) begin
							jaro_q  <= (l2_q == '0) ? Q16_ONE : 17'd0;
							state_q <= ST_BCHK;
						end else begin
							state_q <= ST_MROW;
						end
					end
				end
				// Start a row and clip the window to the second word, or end the walk after the last row.
				ST_MROW: begin
					if (i_q == l1_q) begin
						i_q <= '0;
						j_q <= '0;
						if (m_q == '0) begin
							jaro_q  <= '0;
							state_q <= ST_BCHK;
						end else begin
							state_q <= ST_TI;
						end
					end else begin
						j_q <= lo_s[SW-1] ? '0 : LW'(lo_s);
						hi_q <= (hi_s > $signed(SW'(l2_q))) ? l2_q : LW'(hi_s);
						state_q <= ST_MCOL;
					end
				end
				// Skip taken slots; probe the next free one.
				ST_MCOL: begin
					if (j_q >= hi_q) begin
						i_q     <= i_q + LW'(1);
						state_q <= ST_MROW;
					end else if (sm_q[j_q[AW-1:0]]) begin
						j_q <= j_q + LW'(1);
					end else begin
						state_q <= ST_MCMP;
					end
				end
				ST_MCMP: begin
					if (rd1_q == rd2_q) begin
						fm_q[i_q[AW-1:0]] <= 1'b1;
						sm_q[j_q[AW-1:0]] <= 1'b1;
						m_q     <= m_q + LW'(1);
						i_q     <= i_q + LW'(1);
						state_q <= ST_MROW;
					end else begin
						j_q     <= j_q + LW'(1);
						state_q <= ST_MCOL;
					end
				end
				// Transposition pass: pair matched characters in order.
				ST_TI: begin
					if (i_q == l1_q) begin
						state_q <= ST_MU1;
					end else if (!fm_q[i_q[AW-1:0]]) begin
						i_q <= i_q + LW'(1);
					end else begin
						state_q <= ST_TK;
					end
				end
				ST_TK: begin
					if (j_q >= l2_q) begin
						state_q <= ST_MU1;
					end else if (!sm_q[j_q[AW-1:0]]) begin
						j_q <= j_q + LW'(1);
					end else begin
						state_q <= ST_TCMP;
					end
				end
				ST_TCMP: begin
					if (rd1_q != rd2_q) begin
						c_q <= c_q + LW'(1);
					end
					i_q     <= i_q + LW'(1);
					j_q     <= j_q + LW'(1);
					state_q <= ST_TI;
				end
				// Numerator and denominator through the shared multiplier.
				ST_MU1: begin
					mm_q    <= (2*LW)'(prod);
					state_q <= ST_MU2;
				end
				ST_MU2: begin
					pa_q    <= NW'(prod);
					state_q <= ST_MU3;
				end
				ST_MU3: begin
					l12_q   <= (2*LW)'(prod);
					state_q <= ST_MU4;
				end
				ST_MU4: begin
					num_q   <= (pa_q << 1) + NW'(prod);
					state_q <= ST_MU5;
				end
				ST_MU5: begin
					den_q   <= (NW'(prod) << 2) + (NW'(prod) << 1);
					state_q <= ST_DINIT;
				end
				ST_DINIT: begin
					rem_q   <= {num_q, 16'd0};
					ds_q    <= {den_q, 16'd0};
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				// Restoring division, one quotient bit per cycle.
				ST_DIV: begin
					if (!trial[RW]) begin
						rem_q <= trial[RW-1:0];
					end
					quo_q <= {quo_q[15:0], !trial[RW]};
					ds_q  <= ds_q >> 1;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) begin
						jaro_q  <= {quo_q[15:0], !trial[RW]};
						state_q <= ST_BCHK;
					end
				end
				ST_BCHK: begin
					i_q <= '0;
					j_q <= '0;
					if (jaro_q > thr_q) begin
						state_q <= ST_PCHK;
					end else begin
						p_q     <= '0;
						result.similarity <= jaro_q;
						state_q <= ST_OUT;
					end
				end
				// Common prefix, bounded by both lengths and the limit.
				ST_PCHK: begin
					if (i_q == l1_q || i_q == l2_q || i_ext == plim_ext) begin
						p_q     <= 4'(i_q);
						state_q <= ST_BM1;
					end else begin
						state_q <= ST_PCMP;
					end
				end
				ST_PCMP: begin
					if (rd1_q == rd2_q) begin
						i_q     <= i_q + LW'(1);
						j_q     <= j_q + LW'(1);
						state_q <= ST_PCHK;
					end else begin
						p_q     <= 4'(i_q);
						state_q <= ST_BM1;
					end
				end
				ST_BM1: begin
					ps_q    <= 19'(prod);
					state_q <= ST_BM2;
				end
				ST_BM2: begin
					bon_q   <= prod[35:16];
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					result.similarity <= (sum > 21'(Q16_ONE)) ? Q16_ONE : 17'(sum);
					state_q <= ST_OUT;
				end
				// Deliver the transaction and clear the words.
				ST_OUT: begin
					result.jaro_score     <= jaro_q;
					result.match_count    <= 7'(m_q);
					result.mismatch_pairs <= 7'(c_q);
					result.prefix_length  <= p_q;
					result.truncated      <= ovf_q;
					done    <= 1'b1;
					l1_q    <= '0;
					l2_q    <= '0;
					fm_q    <= '0;
					sm_q    <= '0;
					ovf_q   <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A result only follows a compute in progress, and lasts one cycle.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without a compute");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held over two cycles");
	a_match_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (m_q <= l1_q && m_q <= l2_q)) else $error("match count too large");
	a_trans_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (c_q <= m_q)) else $error("mismatch count above matches");

endmodule

`default_nettype wire
